/* src/fhg_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fhg_pkg
// Shared types and constants of the fire-effect heat generator.
// ----------------------------------------------------------------------------
package fhg_pkg;

   localparam int CSR_DATA_W  = 9;
   localparam int CSR_INDEX_W = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WIDTH   = 2'd0,
      CSR_HEIGHT  = 2'd1,
      CSR_PERCENT = 2'd2
   } csr_index_type;

   localparam int DIM_W       = 9;
   localparam int PERCENT_W   = 7;
   localparam int HEAT_W      = 8;
   localparam int EVEN_W      = 4;
   localparam int ODD_W       = 6;
   localparam int CHANCE_W    = 7;
   localparam int OUT_COORD_W = 8;
   localparam int SEED_W      = 9;

   localparam logic [DIM_W-1:0]     DIM_RESET     = 9'd256;
   localparam logic [PERCENT_W-1:0] PERCENT_RESET = 7'd100;

   localparam logic [SEED_W-1:0]   BASE_EVEN     = 9'd190;
   localparam logic [SEED_W-1:0]   BASE_ODD      = 9'd100;
   localparam logic [CHANCE_W-1:0] HEAT_UP_LIMIT = 7'd20;

   // Cooling step: 25500 / height / percent, saturated to the step width.
   localparam int STEP_W     = 12;
   localparam int STEP_NUM_W = 15;
   localparam int DIV_CNT_W  = 4;
   localparam logic [STEP_NUM_W-1:0] STEP_NUM   = 15'd25500;
   localparam logic [DIV_CNT_W-1:0]  STEP_BITS  = 4'd15;
   localparam logic [STEP_W-1:0]     STEP_MAX   = 12'd4095;

   // Division by three of a ten-bit sum: (sum * 683) >> 11 is exact below 2048.
   localparam int SUM_W      = 10;
   localparam int PROD_W     = 20;
   localparam int DIV3_SHIFT = 11;
   localparam logic [SUM_W-1:0] DIV3_MUL = 10'd683;

   localparam int ADJ_W = 14;

   typedef struct packed {
      logic bottom;
      logic has_left;
      logic has_right;
      logic heat_up;
      logic frame_end;
   } fhg_class_type;

endpackage
`default_nettype wire

/* src/fhg_req_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fhg_req_if
// Request channel: one beat carries the random values for one pixel.
// ----------------------------------------------------------------------------
interface fhg_req_if;
   logic       valid;
   logic       ready;
   logic [3:0] even_noise;
   logic [5:0] odd_noise;
   logic [6:0] chance;

   modport source (output valid, even_noise, odd_noise, chance, input ready);
   modport sink (input valid, even_noise, odd_noise, chance, output ready);
endinterface
`default_nettype wire

/* src/fhg_rsp_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fhg_rsp_if
// Response channel: one beat carries the heat value of one pixel.
// ----------------------------------------------------------------------------
interface fhg_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] column;
   logic [7:0] row;
   logic [7:0] heat;
   logic       frame_end;

   modport source (output valid, column, row, heat, frame_end, input ready);
   modport sink (input valid, column, row, heat, frame_end, output ready);
endinterface
`default_nettype wire

/* src/fhg_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fhg_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module fhg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic             re,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

/* src/fhg_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fhg_queue
// Two-entry queue that decouples pixel classification from heat computation.
// ----------------------------------------------------------------------------
module fhg_queue #(
   parameter int WIDTH = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic                  pop_valid,
   output logic      [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full      = (count_ff == 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_data  = slot_ff[rd_ptr_ff];

endmodule
`default_nettype wire

/* src/fhg_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fhg_front
// Accepts request beats, tracks the raster position and classifies each pixel.
// ----------------------------------------------------------------------------
module fhg_front import fhg_pkg::*; #(
   parameter int MAX_WIDTH    = 256,
   parameter int MAX_HEIGHT   = 256,
   parameter int PALETTE_SIZE = 200,
   localparam int CW = $clog2(MAX_WIDTH),
   localparam int RW = $clog2(MAX_HEIGHT),
   localparam int WW = $clog2(MAX_WIDTH + 1),
   localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic [WW-1:0] width_eff,
   input  wire logic [HW-1:0] height_eff,
   input  wire logic          hold,
   input  wire logic          queue_full,
   fhg_req_if.sink            req_if,
   output logic               push,
   output logic [CW-1:0]      push_x,
   output logic [RW-1:0]      push_y,
   output fhg_class_type      push_class,
   output logic [HEAT_W-1:0]  push_seed
);

   localparam logic [SEED_W-1:0] SEED_MAX = SEED_W'(PALETTE_SIZE - 1);

   logic [CW-1:0]     col_ff, col_in;
   logic [RW-1:0]     row_ff, row_in;
   logic              col_wrap;
   logic [RW:0]       row_up;
   logic [CW-1:0]     x;
   logic [RW-1:0]     y;
   logic [CW:0]       x_inc;
   logic [RW:0]       y_inc;
   logic              last_col;
   logic              last_row;
   logic              accept;
   logic [SEED_W-1:0] seed_raw;

   // A counter left beyond a smaller geometry wraps before the pixel is placed.
   always_comb begin
      col_wrap = (col_ff >= width_eff);
      row_up   = {1'b0, row_ff} + (RW+1)'(col_wrap);
      x        = col_wrap ? '0 : col_ff;
      y        = (row_up >= height_eff) ? '0 : row_up[RW-1:0];
      x_inc    = {1'b0, x} + (CW+1)'(1);
      y_inc    = {1'b0, y} + (RW+1)'(1);
      last_col = (x_inc == width_eff);
      last_row = (y_inc == height_eff);
      seed_raw = x[0] ? BASE_ODD + SEED_W'(req_if.odd_noise)
                      : BASE_EVEN + SEED_W'(req_if.even_noise);
   end

   assign req_if.ready = !queue_full && !hold;
   assign accept       = req_if.valid && req_if.ready;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : y_inc[RW-1:0];
         end else begin
            col_in = x_inc[CW-1:0];
            row_in = y;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   always_comb begin
      push                 = accept;
      push_x               = x;
      push_y               = y;
      push_class.bottom    = (y == '0);
      push_class.has_left  = (x != '0);
      push_class.has_right = !last_col;
      push_class.heat_up   = (req_if.chance < HEAT_UP_LIMIT);
      push_class.frame_end = last_col && last_row;
      push_seed            = (seed_raw > SEED_MAX) ? SEED_MAX[HEAT_W-1:0]
                                                   : seed_raw[HEAT_W-1:0];
   end

endmodule
`default_nettype wire

/* src/fhg_step_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fhg_step_div
// Restoring divider for the cooling step, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fhg_step_div import fhg_pkg::*; #(
   parameter int MAX_HEIGHT = 256,
   localparam int HW = $clog2(MAX_HEIGHT + 1),
   localparam int DW = HW + PERCENT_W
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [HW-1:0]        height_eff,
   input  wire logic [PERCENT_W-1:0] percent,
   output logic                      busy,
   output logic [STEP_W-1:0]         cool_step
);

   logic                  start_ff;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DW-1:0]         divisor_ff, divisor_in;
   logic [DW-1:0]         rem_ff, rem_in;
   logic [STEP_NUM_W-1:0] quo_ff, quo_in;
   logic [PERCENT_W-1:0]  percent_eff;
   logic [DIV_CNT_W-1:0]  bit_idx;
   logic [DW:0]           rem_try;
   logic                  fits;

   // The step is floor(25500 / (height * percent)), which equals the two
   // successive truncating divisions.
   always_comb begin
      percent_eff = (percent == '0) ? PERCENT_W'(1) : percent;
      bit_idx     = cnt_ff - DIV_CNT_W'(1);
      rem_try     = {rem_ff, STEP_NUM[bit_idx]};
      fits        = (rem_try >= {1'b0, divisor_ff});
      cnt_in      = cnt_ff;
      divisor_in  = divisor_ff;
      rem_in      = rem_ff;
      quo_in      = quo_ff;
      if (start_ff) begin
         cnt_in     = STEP_BITS;
         divisor_in = DW'(height_eff) * DW'(percent_eff);
         rem_in     = '0;
         quo_in     = '0;
      end else if (cnt_ff != '0) begin
         cnt_in = bit_idx;
         rem_in = fits ? DW'(rem_try - {1'b0, divisor_ff}) : rem_try[DW-1:0];
         quo_in = {quo_ff[STEP_NUM_W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= 1'b1;
         cnt_ff   <= '0;
      end else begin
         start_ff <= start;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      divisor_ff <= divisor_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
   end

   assign busy      = start_ff || (cnt_ff != '0);
   assign cool_step = (quo_ff > STEP_NUM_W'(STEP_MAX)) ? STEP_MAX : quo_ff[STEP_W-1:0];

endmodule
`default_nettype wire

/* src/fhg_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fhg_back
// Reads the line buffer, computes the heat of each pixel and drives the
// response register.
// ----------------------------------------------------------------------------
module fhg_back import fhg_pkg::*; #(
   parameter int MAX_WIDTH    = 256,
   parameter int MAX_HEIGHT   = 256,
   parameter int PALETTE_SIZE = 200,
   localparam int CW = $clog2(MAX_WIDTH),
   localparam int RW = $clog2(MAX_HEIGHT)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_valid,
   input  wire logic [CW-1:0]     q_x,
   input  wire logic [RW-1:0]     q_y,
   input  wire fhg_class_type     q_class,
   input  wire logic [HEAT_W-1:0] q_seed,
   input  wire logic [STEP_W-1:0] cool_step,
   output logic                   q_pop,
   fhg_rsp_if.source              rsp_if
);

   localparam logic [HEAT_W-1:0] HEAT_MAX = HEAT_W'(PALETTE_SIZE - 1);

   logic                 b_valid_ff, b_valid_in;
   logic [CW-1:0]        b_x_ff;
   logic [RW-1:0]        b_y_ff;
   fhg_class_type        b_class_ff;
   logic [HEAT_W-1:0]    b_seed_ff;
   logic                 fwd_c_ff, fwd_r_ff;
   logic [HEAT_W-1:0]    fwd_heat_ff;
   logic [HEAT_W-1:0]    left_below_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [OUT_COORD_W-1:0] column_ff, row_ff;
   logic [HEAT_W-1:0]    heat_ff;
   logic                 frame_end_ff;

   logic                 out_free;
   logic                 b_move;
   logic                 load;
   logic [CW-1:0]        x_right;
   logic [HEAT_W-1:0]    rd_center, rd_right;
   logic [HEAT_W-1:0]    center, right;
   logic [SUM_W-1:0]     sum;
   logic [PROD_W-1:0]    prod;
   logic [HEAT_W-1:0]    avg;
   logic [ADJ_W-1:0]     adj;
   logic [HEAT_W-1:0]    cooled;
   logic [HEAT_W-1:0]    b_heat;

   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign b_move   = b_valid_ff && out_free;
   assign load     = q_valid && (!b_valid_ff || b_move);
   assign q_pop    = load;
   assign x_right  = q_x + CW'(1);

   fhg_ram #(.WIDTH(HEAT_W), .DEPTH(MAX_WIDTH)) u_ram_center (
      .clock (clock),
      .we    (b_move),
      .waddr (b_x_ff),
      .wdata (b_heat),
      .re    (load),
      .raddr (q_x),
      .rdata (rd_center)
   );

   fhg_ram #(.WIDTH(HEAT_W), .DEPTH(MAX_WIDTH)) u_ram_right (
      .clock (clock),
      .we    (b_move),
      .waddr (b_x_ff),
      .wdata (b_heat),
      .re    (load),
      .raddr (x_right),
      .rdata (rd_right)
   );

   // The pixel leaving this stage writes the buffer in the same cycle as the
   // next pixel reads it, so its heat is forwarded when the addresses match.
   always_comb begin
      center = fwd_c_ff ? fwd_heat_ff : rd_center;
      right  = fwd_r_ff ? fwd_heat_ff : rd_right;
      sum    = {1'b0, center, 1'b0}
             + (b_class_ff.has_left  ? SUM_W'(left_below_ff) : '0)
             + (b_class_ff.has_right ? SUM_W'(right) : '0);
      prod   = PROD_W'(sum) * PROD_W'(DIV3_MUL);
      unique case ({b_class_ff.has_left, b_class_ff.has_right})
         2'b11:   avg = sum[SUM_W-1:2];
         2'b00:   avg = sum[HEAT_W:1];
         default: avg = prod[DIV3_SHIFT +: HEAT_W];
      endcase
      adj = b_class_ff.heat_up ? ADJ_W'(avg) + ADJ_W'(cool_step)
                               : ADJ_W'(avg) - ADJ_W'(cool_step);
      priority if (adj[ADJ_W-1]) begin
         cooled = '0;
      end else if (adj > ADJ_W'(HEAT_MAX)) begin
         cooled = HEAT_MAX;
      end else begin
         cooled = adj[HEAT_W-1:0];
      end
      priority if (b_class_ff.bottom) begin
         b_heat = b_seed_ff;
      end else if (avg == '0) begin
         b_heat = '0;
      end else begin
         b_heat = cooled;
      end
   end

   always_comb begin
      b_valid_in = b_valid_ff;
      if (load) begin
         b_valid_in = 1'b1;
      end else if (b_move) begin
         b_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (b_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         left_below_ff <= '0;
      end else begin
         b_valid_ff   <= b_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (b_move) begin
            left_below_ff <= center;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         b_x_ff      <= q_x;
         b_y_ff      <= q_y;
         b_class_ff  <= q_class;
         b_seed_ff   <= q_seed;
         fwd_c_ff    <= b_move && (b_x_ff == q_x);
         fwd_r_ff    <= b_move && (b_x_ff == x_right);
         fwd_heat_ff <= b_heat;
      end
      if (b_move) begin
         column_ff    <= OUT_COORD_W'(b_x_ff);
         row_ff       <= OUT_COORD_W'(b_y_ff);
         heat_ff      <= b_heat;
         frame_end_ff <= b_class_ff.frame_end;
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.column    = column_ff;
   assign rsp_if.row       = row_ff;
   assign rsp_if.heat      = heat_ff;
   assign rsp_if.frame_end = frame_end_ff;

endmodule
`default_nettype wire

/* src/fire_effect_heat_generator.sv */
`default_nettype none
// An accepted request passes the queue, the buffer-read stage and the response
// register; one pixel per cycle is sustained while rsp ready holds high.
// Each buffer copy takes one read and one write per pixel, forwarded at row wraps.
// Reset clears position counters and pipeline valids; the line buffer is not
// cleared. After reset and after every register write, req ready is low while
// the cooling step is divided out one bit per cycle.
// ----------------------------------------------------------------------------
// fire_effect_heat_generator
// Produces the heat value of each pixel of a fire effect in raster order.
// ----------------------------------------------------------------------------
module fire_effect_heat_generator import fhg_pkg::*; #(
   parameter int MAX_WIDTH    = 256,
   parameter int MAX_HEIGHT   = 256,
   parameter int PALETTE_SIZE = 200
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   fhg_req_if.sink                     req_if,
   fhg_rsp_if.source                   rsp_if,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int RW  = $clog2(MAX_HEIGHT);
   localparam int WW  = $clog2(MAX_WIDTH + 1);
   localparam int HW  = $clog2(MAX_HEIGHT + 1);
   localparam int Q_W = CW + RW + $bits(fhg_class_type) + HEAT_W;

   logic [DIM_W-1:0]     width_ff;
   logic [DIM_W-1:0]     height_ff;
   logic [PERCENT_W-1:0] percent_ff;
   logic [WW-1:0]        width_eff;
   logic [HW-1:0]        height_eff;

   logic                 step_busy;
   logic [STEP_W-1:0]    cool_step;

   logic                 push;
   logic [CW-1:0]        push_x;
   logic [RW-1:0]        push_y;
   fhg_class_type        push_class;
   logic [HEAT_W-1:0]    push_seed;
   logic [Q_W-1:0]       q_push_data;
   logic                 q_full;
   logic                 q_pop;
   logic                 q_valid;
   logic [Q_W-1:0]       q_pop_data;
   logic [CW-1:0]        q_x;
   logic [RW-1:0]        q_y;
   fhg_class_type        q_class;
   logic [HEAT_W-1:0]    q_seed;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= DIM_RESET;
         height_ff  <= DIM_RESET;
         percent_ff <= PERCENT_RESET;
      end else if (csr_we) begin
         if (csr_index == CSR_WIDTH) begin
            width_ff <= csr_wdata;
         end
         if (csr_index == CSR_HEIGHT) begin
            height_ff <= csr_wdata;
         end
         if (csr_index == CSR_PERCENT) begin
            percent_ff <= csr_wdata[PERCENT_W-1:0];
         end
      end
   end

   // Zero counts as one; larger values saturate at MAX_WIDTH and MAX_HEIGHT.
   always_comb begin
      priority if (width_ff == '0) begin
         width_eff = WW'(1);
      end else if (width_ff > MAX_WIDTH) begin
         width_eff = WW'(MAX_WIDTH);
      end else begin
         width_eff = WW'(width_ff);
      end
      priority if (height_ff == '0) begin
         height_eff = HW'(1);
      end else if (height_ff > MAX_HEIGHT) begin
         height_eff = HW'(MAX_HEIGHT);
      end else begin
         height_eff = HW'(height_ff);
      end
   end

   fhg_step_div #(.MAX_HEIGHT(MAX_HEIGHT)) u_step_div (
      .clock      (clock),
      .reset      (reset),
      .start      (csr_we),
      .height_eff (height_eff),
      .percent    (percent_ff),
      .busy       (step_busy),
      .cool_step  (cool_step)
   );

   fhg_front #(
      .MAX_WIDTH    (MAX_WIDTH),
      .MAX_HEIGHT   (MAX_HEIGHT),
      .PALETTE_SIZE (PALETTE_SIZE)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .width_eff  (width_eff),
      .height_eff (height_eff),
      .hold       (step_busy),
      .queue_full (q_full),
      .req_if     (req_if),
      .push       (push),
      .push_x     (push_x),
      .push_y     (push_y),
      .push_class (push_class),
      .push_seed  (push_seed)
   );

   assign q_push_data = {push_x, push_y, push_class, push_seed};

   fhg_queue #(.WIDTH(Q_W)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_data  (q_pop_data)
   );

   assign {q_x, q_y, q_class, q_seed} = q_pop_data;

   fhg_back #(
      .MAX_WIDTH    (MAX_WIDTH),
      .MAX_HEIGHT   (MAX_HEIGHT),
      .PALETTE_SIZE (PALETTE_SIZE)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_x       (q_x),
      .q_y       (q_y),
      .q_class   (q_class),
      .q_seed    (q_seed),
      .cool_step (cool_step),
      .q_pop     (q_pop),
      .rsp_if    (rsp_if)
   );

endmodule
`default_nettype wire

/* src/fhg_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fhg_checker
// Port-level checks of the fire-effect heat generator, bound to the top level.
// ----------------------------------------------------------------------------
module fhg_checker #(
   parameter int PALETTE_SIZE = 200
) (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_column,
   input wire logic [7:0] rsp_row,
   input wire logic [7:0] rsp_heat,
   input wire logic       rsp_frame_end
);

   logic [2:0] inflight_ff, inflight_in;

   // Beats taken in but not yet delivered.
   always_comb begin
      inflight_in = inflight_ff + 3'(req_valid && req_ready) - 3'(rsp_valid && rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable({rsp_column, rsp_row, rsp_heat, rsp_frame_end}))
      else $error("response beat changed while stalled");

   a_heat_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_heat < PALETTE_SIZE))
      else $error("heat value beyond palette");

   a_no_orphan : assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || inflight_ff != 3'd0) && (inflight_ff <= 3'd4))
      else $error("response without a pending request or too many in flight");

   a_step_after_reset : assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> !req_ready)
      else $error("request accepted before the cooling step was computed");

endmodule

bind fire_effect_heat_generator fhg_checker #(.PALETTE_SIZE(PALETTE_SIZE)) u_fhg_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_if.valid),
   .req_ready     (req_if.ready),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .rsp_column    (rsp_if.column),
   .rsp_row       (rsp_if.row),
   .rsp_heat      (rsp_if.heat),
   .rsp_frame_end (rsp_if.frame_end)
);
`default_nettype wire

/* verif/tb_fire_effect_heat_generator.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tb_fire_effect_heat_generator
// Drives random pixel requests into the fire-effect heat generator, predicts
// the heat of every pixel from its own copy of the line buffer, the raster
// position and the cooling step, and checks each response beat in order.
// Geometry and flame height are reprogrammed between phases while idle.
// ----------------------------------------------------------------------------
module tb_fire_effect_heat_generator import fhg_pkg::*;;

   localparam int CLK_PERIOD     = 20;
   localparam int RESET_CYCLES   = 8;
   localparam int DRAIN_CYCLES   = 8;
   localparam int RANDOM_ITEMS   = 520;
   localparam int TIMEOUT_CYCLES = 400000;

   localparam int MAX_WIDTH     = 256;
   localparam int MAX_HEIGHT    = 256;
   localparam int PALETTE_SIZE  = 200;
   localparam int EVEN_BASE     = 190;
   localparam int ODD_BASE      = 100;
   localparam int HEAT_UP_BELOW = 20;
   localparam int STEP_DIVIDEND = 25500;
   localparam int STEP_LIMIT    = 4095;

   typedef struct packed {
      logic [OUT_COORD_W-1:0] column;
      logic [OUT_COORD_W-1:0] row;
      logic [HEAT_W-1:0]      heat;
      logic                   frame_end;
   } heat_pixel_type;

   class fire_pixel_scoreboard;
      logic [DIM_W-1:0]     width_reg;
      logic [DIM_W-1:0]     height_reg;
      logic [PERCENT_W-1:0] percent_reg;
      logic [HEAT_W-1:0]    line_below [MAX_WIDTH];
      logic [HEAT_W-1:0]    left_below;
      int unsigned          col_pos;
      int unsigned          row_pos;
      int                   step;
      heat_pixel_type       expected_pixels [$];
      int                   error_count;

      function new();
         width_reg   = 9'd256;
         height_reg  = 9'd256;
         percent_reg = 7'd100;
         foreach (line_below[i]) line_below[i] = '0;
         left_below  = '0;
         col_pos     = 0;
         row_pos     = 0;
         error_count = 0;
         refresh_step();
      endfunction

      function int unsigned clamp_dimension(logic [DIM_W-1:0] value, int unsigned limit);
         if (value == 0) return 1;
         if (value > limit) return limit;
         return value;
      endfunction

      function int clamp_heat(int value);
         if (value < 0) return 0;
         if (value > PALETTE_SIZE - 1) return PALETTE_SIZE - 1;
         return value;
      endfunction

      function void refresh_step();
         int unsigned rows;
         int unsigned percent;
         int unsigned quotient;
         rows     = clamp_dimension(height_reg, MAX_HEIGHT);
         percent  = (percent_reg == 0) ? 1 : percent_reg;
         quotient = STEP_DIVIDEND / rows / percent;
         step     = (quotient > STEP_LIMIT) ? STEP_LIMIT : quotient;
      endfunction

      function void write_register(csr_index_type index, logic [CSR_DATA_W-1:0] data);
         case (index)
            CSR_WIDTH:   width_reg   = data;
            CSR_HEIGHT:  height_reg  = data;
            CSR_PERCENT: percent_reg = data[PERCENT_W-1:0];
            default: return;
         endcase
         refresh_step();
      endfunction

      function void note_request(logic [EVEN_W-1:0] even_noise, logic [ODD_W-1:0] odd_noise,
                                 logic [CHANCE_W-1:0] chance);
         int unsigned cols;
         int unsigned rows;
         int          heat;
         int          sum;
         int          taps;
         logic [HEAT_W-1:0] below;
         heat_pixel_type pixel;
         cols = clamp_dimension(width_reg, MAX_WIDTH);
         rows = clamp_dimension(height_reg, MAX_HEIGHT);
         // A position left beyond a shrunken geometry wraps before this pixel.
         if (col_pos >= cols) begin
            col_pos = 0;
            row_pos++;
         end
         if (row_pos >= rows) row_pos = 0;
         below = line_below[col_pos];
         if (row_pos == 0) begin
            if (col_pos % 2 == 0) heat = EVEN_BASE + int'(even_noise);
            else heat = ODD_BASE + int'(odd_noise);
            heat = clamp_heat(heat);
         end else begin
            // The cell directly below carries double weight.
            sum  = 2 * int'(below);
            taps = 2;
            if (col_pos > 0) begin
               sum += int'(left_below);
               taps++;
            end
            if (col_pos + 1 < cols) begin
               sum += int'(line_below[col_pos + 1]);
               taps++;
            end
            heat = sum / taps;
            if (heat > 0) begin
               if (chance < HEAT_UP_BELOW) heat += step;
               else heat -= step;
               heat = clamp_heat(heat);
            end
         end
         left_below          = below;
         line_below[col_pos] = heat[HEAT_W-1:0];
         pixel.column    = col_pos[OUT_COORD_W-1:0];
         pixel.row       = row_pos[OUT_COORD_W-1:0];
         pixel.heat      = heat[HEAT_W-1:0];
         pixel.frame_end = (col_pos + 1 == cols) && (row_pos + 1 == rows);
         expected_pixels.push_back(pixel);
         col_pos++;
         if (col_pos >= cols) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= rows) row_pos = 0;
         end
      endfunction

      function void compare_field(string name, logic [7:0] expected, logic [7:0] actual);
         if (actual !== expected) begin
            $error("%s: expected %0d, actual %0d", name, expected, actual);
            error_count++;
         end
      endfunction

      function void check_response(logic [OUT_COORD_W-1:0] column, logic [OUT_COORD_W-1:0] row,
                                   logic [HEAT_W-1:0] heat, logic frame_end);
         heat_pixel_type pixel;
         if (expected_pixels.size() == 0) begin
            $error("response beat at column %0d row %0d with no pixel pending", column, row);
            error_count++;
            return;
         end
         pixel = expected_pixels.pop_front();
         compare_field("column", pixel.column, column);
         compare_field("row", pixel.row, row);
         compare_field("heat", pixel.heat, heat);
         compare_field("frame_end", {7'd0, pixel.frame_end}, {7'd0, frame_end});
      endfunction

      function int pending();
         return expected_pixels.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   fhg_req_if req_bus ();
   fhg_rsp_if rsp_bus ();

   fire_pixel_scoreboard board;
   int req_burst = 0;
   int rsp_burst = 0;
   int random_items = 0;

   fire_effect_heat_generator #(
      .MAX_WIDTH   (MAX_WIDTH),
      .MAX_HEIGHT  (MAX_HEIGHT),
      .PALETTE_SIZE(PALETTE_SIZE)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_if   (req_bus),
      .rsp_if   (rsp_bus),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Idle cycles before the next beat; now and then a long stretch with none.
   function automatic int draw_wait(inout int burst_left);
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         burst_left = $urandom_range(20, 80);
         return 0;
      end
      return $urandom_range(0, 6);
   endfunction

   function automatic logic [DIM_W-1:0] pick_dimension();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return DIM_W'($urandom_range(1, 8));
      if (roll < 85) return DIM_W'($urandom_range(9, 64));
      if (roll < 92) return DIM_W'($urandom_range(65, 255));
      if (roll < 95) return 9'd256;
      if (roll < 98) return DIM_W'($urandom_range(257, 511));
      return '0;
   endfunction

   function automatic logic [PERCENT_W-1:0] pick_percent();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return 7'd10;
      if (roll == 1) return 7'd100;
      if (roll == 2) return PERCENT_W'($urandom_range(0, 9));
      if (roll == 3) return PERCENT_W'($urandom_range(101, 127));
      return PERCENT_W'($urandom_range(10, 100));
   endfunction

   // Valid stays high across beats when no gap is drawn, so it is only
   // lowered here when the next beat really waits.
   task automatic send_request(input logic [EVEN_W-1:0] even_noise,
                               input logic [ODD_W-1:0] odd_noise,
                               input logic [CHANCE_W-1:0] chance);
      int gap;
      gap = draw_wait(req_burst);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.even_noise <= even_noise;
      req_bus.odd_noise  <= odd_noise;
      req_bus.chance     <= chance;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      board.note_request(even_noise, odd_noise, chance);
   endtask

   task automatic send_random_pixel();
      if ($urandom_range(0, 9) != 0) begin
         send_request(EVEN_W'($urandom_range(0, 9)), ODD_W'($urandom_range(0, 49)),
                      CHANCE_W'($urandom_range(0, 99)));
      end else begin
         send_request(EVEN_W'($urandom_range(0, 15)), ODD_W'($urandom_range(0, 63)),
                      CHANCE_W'($urandom_range(0, 127)));
      end
   endtask

   task automatic end_phase();
      req_bus.valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type index, input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      board.write_register(index, data);
   endtask

   task automatic program_registers(input logic [2:0] select, input logic [DIM_W-1:0] width,
                                    input logic [DIM_W-1:0] height,
                                    input logic [PERCENT_W-1:0] percent);
      if (select[CSR_WIDTH]) write_csr(CSR_WIDTH, width);
      if (select[CSR_HEIGHT]) write_csr(CSR_HEIGHT, height);
      if (select[CSR_PERCENT]) write_csr(CSR_PERCENT, {2'b00, percent});
      csr_we <= 1'b0;
   endtask

   initial begin
      int count;
      board = new();
      req_bus.valid      <= 1'b0;
      req_bus.even_noise <= '0;
      req_bus.odd_noise  <= '0;
      req_bus.chance     <= '0;
      csr_we             <= 1'b0;
      csr_index          <= CSR_WIDTH;
      csr_wdata          <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // The first bottom row at full width writes every line-buffer entry,
      // so no later row reads an entry that was never written.
      send_request(4'd0, 6'd0, 7'd0);
      send_request(4'd0, 6'd0, 7'd0);
      send_request(4'd15, 6'd63, 7'd127);
      send_request(4'd15, 6'd63, 7'd127);
      send_request(4'd9, 6'd49, 7'd99);
      send_request(4'd9, 6'd49, 7'd99);
      for (int i = 6; i < MAX_WIDTH; i++) send_random_pixel();

      // Zero geometry and percent: one pixel frames, saturated step.
      end_phase();
      program_registers(3'b111, 9'd0, 9'd0, 7'd0);
      send_request(4'd9, 6'd49, 7'd0);
      send_request(4'd0, 6'd0, 7'd99);

      // Large step: cooling reaches zero, and a zero average stays at zero
      // whatever the chance.
      end_phase();
      program_registers(3'b111, 9'd2, 9'd3, 7'd10);
      send_request(4'd9, 6'd0, 7'd0);
      send_request(4'd0, 6'd49, 7'd0);
      send_request(4'd0, 6'd0, 7'd20);
      send_request(4'd0, 6'd0, 7'd99);
      send_request(4'd0, 6'd0, 7'd0);
      send_request(4'd0, 6'd0, 7'd127);

      end_phase();
      program_registers(3'b111, 9'd5, 9'd2, 7'd100);
      send_request(4'd15, 6'd0, 7'd0);
      send_request(4'd0, 6'd63, 7'd0);
      send_request(4'd9, 6'd49, 7'd0);
      send_request(4'd0, 6'd0, 7'd0);
      send_request(4'd1, 6'd1, 7'd0);
      send_request(4'd0, 6'd0, 7'd19);
      send_request(4'd0, 6'd0, 7'd50);

      // Shrinking the width mid-frame wraps the column and the row.
      end_phase();
      program_registers(3'b001, 9'd2, 9'd0, 7'd0);
      send_request(4'd3, 6'd7, 7'd0);
      send_request(4'd5, 6'd30, 7'd0);

      // Oversized height saturates to the maximum.
      end_phase();
      program_registers(3'b110, 9'd0, 9'd511, 7'd1);
      send_request(4'd0, 6'd0, 7'd19);
      send_request(4'd0, 6'd0, 7'd20);
      send_request(4'd0, 6'd0, 7'd0);

      while (random_items < RANDOM_ITEMS) begin
         end_phase();
         program_registers(3'($urandom_range(1, 7)), pick_dimension(), pick_dimension(),
                           pick_percent());
         count = $urandom_range(10, 60);
         repeat (count) begin
            send_random_pixel();
            random_items++;
         end
      end

      end_phase();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Response side: ready stays high across beats when no stall is drawn.
   initial begin
      int stall;
      rsp_bus.ready <= 1'b0;
      wait (reset === 1'b0);
      forever begin
         stall = draw_wait(rsp_burst);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1);
         board.check_response(rsp_bus.column, rsp_bus.row, rsp_bus.heat, rsp_bus.frame_end);
      end
   end

   initial begin
      #(TIMEOUT_CYCLES * CLK_PERIOD);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
`default_nettype wire

/* filelist.f */
src/fhg_pkg.sv
src/fhg_req_if.sv
src/fhg_rsp_if.sv
src/fhg_ram.sv
src/fhg_queue.sv
src/fhg_front.sv
src/fhg_step_div.sv
src/fhg_back.sv
src/fire_effect_heat_generator.sv
src/fhg_checker.sv
verif/tb_fire_effect_heat_generator.sv
